FILE: design/zobrist_transposition_table_unit_assert.svh
// Assertion macros shared by the transposition table checkers.
// Needs nothing else; included by files that assert.
`ifndef ZOBRIST_TRANSPOSITION_TABLE_UNIT_ASSERT_SVH
`define ZOBRIST_TRANSPOSITION_TABLE_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ZTT_ASSERT_NOW(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("zobtt check failed");

// antecedent implies consequent in the next cycle
`define ZTT_ASSERT_NEXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("zobtt check failed");

`endif

FILE: design/zobtt_pkg.sv
// Types and codes for the Zobrist transposition table unit.
// No dependencies.
package zobtt_pkg;

	localparam logic [2:0] KIND_CLEAR  = 3'd0;
	localparam logic [2:0] KIND_INSERT = 3'd1;
	localparam logic [2:0] KIND_LOOKUP = 3'd2;
	localparam logic [2:0] KIND_STEP   = 3'd3;
	localparam logic [2:0] KIND_LOAD   = 3'd4;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic [2:0]         kind;
		logic               side;
		logic               piece;
		logic [5:0]         square;
		logic [15:0]        move_word;
		logic signed [15:0] score;
		logic signed [7:0]  depth;
		logic [1:0]         bound_flag;
		logic [63:0]        random_word;
	} item_t;

	typedef struct packed {
		logic         valid;
		item_t        item;
	} q_head_t;

	typedef struct packed {
		logic               hit;
		logic [15:0]        found_move;
		logic signed [15:0] found_score;
		logic signed [7:0]  found_depth;
		logic [1:0]         found_flag;
	} result_t;

endpackage

FILE: design/zobtt_front.sv
// Front end: accepts item beats into a short queue ahead of the back end.
// Depends on zobtt_pkg.
module zobtt_front import zobtt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept_en,
	input  logic    in_valid,
	output logic    in_ready,
	input  item_t   in_item,
	output q_head_t head,
	input  logic    pop
);

	item_t             q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              do_pop;

	assign in_ready   = accept_en && (count_q != (QPTR_W+1)'(QDEPTH));
	assign push       = in_valid && in_ready;
	assign head.valid = (count_q != '0);
	assign head.item  = q_mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: design/zobtt_back.sv
// Back end: position key, random word bank, both tables and the result register.
// Depends on zobtt_pkg.
module zobtt_back import zobtt_pkg::*; #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int MOVE_BITS     = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  q_head_t head,
	output logic    pop,
	output logic    ready_en,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int ADDR_W = IDX_W + 1;
	localparam int FL_LSB = 0;
	localparam int DP_LSB = 2;
	localparam int SC_LSB = 10;
	localparam int MV_LSB = 26;
	localparam int KY_LSB = MV_LSB + MOVE_BITS;
	localparam int ENT_W  = KY_LSB + 64;
	localparam int DEPTH  = 2 * TABLE_ENTRIES;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_CLEAR = 2'd2;

	logic [1:0]        state_q;
	logic              init_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic [63:0]       key_q;
	item_t             cur_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic [ENT_W-1:0]  tbl_mem [DEPTH];
	logic [ENT_W-1:0]  tbl_rd_q;
	logic [63:0]       rnd_mem [256];
	logic [63:0]       rnd_rd_q;

	logic              tbl_re;
	logic              tbl_we;
	logic [ADDR_W-1:0] tbl_waddr;
	logic [ENT_W-1:0]  tbl_wdata;
	logic [ADDR_W-1:0] rd_addr;
	logic              rnd_re;
	logic              rnd_we;
	logic [7:0]        rnd_addr;

	logic [31:0]       new_mv_ext;
	logic [31:0]       rd_mv_ext;
	logic              hit;
	logic              replace;
	logic              out_free;
	logic              is_idle;
	logic              res_load;

	assign is_idle    = (state_q == ST_IDLE);
	assign pop        = is_idle && head.valid;
	assign ready_en   = !init_q;
	assign rd_addr    = {head.item.side, key_q[IDX_W-1:0]};
	assign rnd_addr   = {head.item.side, head.item.piece, head.item.square};
	assign out_free   = !res_valid || res_ready;
	assign res_load   = (state_q == ST_EXEC) && (cur_s1.kind == KIND_LOOKUP) && out_free;
	assign new_mv_ext = {16'b0, cur_s1.move_word};
	assign rd_mv_ext  = 32'(tbl_rd_q[MV_LSB +: MOVE_BITS]);
	assign hit        = (tbl_rd_q[KY_LSB +: 64] == key_q);
	assign replace    = $signed(tbl_rd_q[DP_LSB +: 8]) <= cur_s1.depth;

	always_comb begin
		tbl_re = 1'b0;
		rnd_re = 1'b0;
		rnd_we = 1'b0;
		if (pop) begin
			case (head.item.kind)
				KIND_INSERT, KIND_LOOKUP: tbl_re = 1'b1;
				KIND_STEP:                rnd_re = 1'b1;
				KIND_LOAD:                rnd_we = 1'b1;
				default:                  ;
			endcase
		end
	end

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = addr_s1;
		tbl_wdata = {key_q, new_mv_ext[MOVE_BITS-1:0], cur_s1.score,
			cur_s1.depth, cur_s1.bound_flag};
		if (state_q == ST_CLEAR) begin
			tbl_we    = 1'b1;
			tbl_waddr = clr_cnt_q;
			tbl_wdata = '0;
		end else if (state_q == ST_EXEC && cur_s1.kind == KIND_INSERT) begin
			tbl_we = replace;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		if (tbl_re) begin
			tbl_rd_q <= tbl_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rnd_we) begin
			rnd_mem[rnd_addr] <= head.item.random_word;
		end
		if (rnd_re) begin
			rnd_rd_q <= rnd_mem[rnd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_s1  <= head.item;
			addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			init_q    <= 1'b1;
			clr_cnt_q <= '0;
			key_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid <= 1'b1;
			end else if (res_valid && res_ready) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (head.item.kind)
							KIND_CLEAR: begin
								state_q   <= ST_CLEAR;
								clr_cnt_q <= '0;
							end
							KIND_INSERT, KIND_LOOKUP, KIND_STEP: state_q <= ST_EXEC;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_EXEC: begin
					case (cur_s1.kind)
						KIND_STEP: begin
							key_q   <= key_q ^ rnd_rd_q;
							state_q <= ST_IDLE;
						end
						KIND_LOOKUP: begin
							if (out_free) begin
								state_q <= ST_IDLE;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
						init_q  <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res.hit <= hit;
			if (hit) begin
				res.found_move  <= rd_mv_ext[15:0];
				res.found_score <= tbl_rd_q[SC_LSB +: 16];
				res.found_depth <= tbl_rd_q[DP_LSB +: 8];
				res.found_flag  <= tbl_rd_q[FL_LSB +: 2];
			end else begin
				res.found_move  <= '0;
				res.found_score <= '0;
				res.found_depth <= '0;
				res.found_flag  <= '0;
			end
		end
	end

endmodule

FILE: design/zobrist_transposition_table_unit.sv
// Top level of the Zobrist transposition table unit.
// Depends on zobtt_pkg, zobtt_front and zobtt_back.
//
// channel  dir  tdata (low bit up)                                  tuser
// s_axis   in   side, piece, square[6], move_word[16], score[16],   kind[3]
//               depth[8], bound_flag[2], random_word[64], pad[6]
// m_axis   out  found_move[16], found_score[16], found_depth[8],    hit
//               found_flag[2], pad[6]
//
// In the back end, insert, lookup and step first read the table or random
// bank, then compare/write or update the key; load and unused kinds are
// handled without leaving idle. Clear sweeps both tables one slot a cycle.
// After reset the same sweep runs first; s_axis_tready stays low meanwhile.
// A 4-beat queue holds input beats while the back end is busy or stalled
// on m_axis_tready; a lookup waits only until the result register is free.
module zobrist_transposition_table_unit import zobtt_pkg::*; #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int MOVE_BITS     = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [119:0] s_axis_tdata,  // side, piece, square, move_word, score, depth, bound_flag, random_word
	input  logic [2:0]   s_axis_tuser,  // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [47:0]  m_axis_tdata,  // found_move, found_score, found_depth, found_flag
	output logic         m_axis_tuser   // hit
);

	item_t   in_item;
	q_head_t head;
	logic    pop;
	logic    ready_en;
	result_t res;

	assign in_item.kind        = s_axis_tuser;
	assign in_item.side        = s_axis_tdata[0];
	assign in_item.piece       = s_axis_tdata[1];
	assign in_item.square      = s_axis_tdata[7:2];
	assign in_item.move_word   = s_axis_tdata[23:8];
	assign in_item.score       = s_axis_tdata[39:24];
	assign in_item.depth       = s_axis_tdata[47:40];
	assign in_item.bound_flag  = s_axis_tdata[49:48];
	assign in_item.random_word = s_axis_tdata[113:50];

	zobtt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept_en (ready_en),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.head      (head),
		.pop       (pop)
	);

	zobtt_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MOVE_BITS     (MOVE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.ready_en  (ready_en),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tuser = res.hit;
	assign m_axis_tdata = {6'b0, res.found_flag, res.found_depth, res.found_score,
		res.found_move};

endmodule

FILE: design/zobtt_checker.sv
// Port-level checks for the Zobrist transposition table unit, bound to the top.
// Depends on zobrist_transposition_table_unit_assert.svh.
`include "zobrist_transposition_table_unit_assert.svh"

module zobtt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [47:0]  m_axis_tdata,
	input logic         m_axis_tuser
);

	logic        stall;
	logic [48:0] out_beat;

	assign stall    = m_axis_tvalid && !m_axis_tready;
	assign out_beat = {m_axis_tuser, m_axis_tdata};

	// stalled result beat holds
	`ZTT_ASSERT_NEXT(a_out_hold, clk, arst_n, stall, m_axis_tvalid)
	`ZTT_ASSERT_NEXT(a_out_stable, clk, arst_n, stall, $stable(out_beat))
	// a miss carries all-zero entry fields
	`ZTT_ASSERT_NOW(a_miss_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 48'd0)
	// pad bits of the result stay zero
	`ZTT_ASSERT_NOW(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[47:42] == 6'd0)

endmodule

bind zobrist_transposition_table_unit zobtt_checker u_zobtt_checker (.*);
